[src/tlpq_pkg.sv]
// Shared constants, codes and controller/datapath types for the three-level priority queue.
package tlpq_pkg;

	localparam int DEPTH    = 64;
	localparam int TAG_BITS = 16;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int CNT_W    = $clog2(DEPTH + 1);
	localparam int FUNC_W   = 2;
	localparam int LVL_W    = 2;
	localparam int STS_W    = 2;

	localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_GET   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_ACCEL = 2'd2;

	localparam logic [LVL_W-1:0] LVL_LOW    = 2'd0;
	localparam logic [LVL_W-1:0] LVL_NORMAL = 2'd1;
	localparam logic [LVL_W-1:0] LVL_HIGH   = 2'd2;

	localparam logic [STS_W-1:0] STS_OK    = 2'd0;
	localparam logic [STS_W-1:0] STS_EMPTY = 2'd1;
	localparam logic [STS_W-1:0] STS_FULL  = 2'd2;

	typedef struct packed {
		logic load;
		logic exec;
		logic commit;
	} tlpq_cmd_t;

	typedef struct packed {
		logic out_busy;
	} tlpq_sts_t;

endpackage

[src/tlpq_if.sv]
// Request and response channel interfaces of the three-level priority queue.
interface tlpq_req_if import tlpq_pkg::*; ;
	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	logic [TAG_BITS-1:0] tag;
	logic [LVL_W-1:0]    level;

	modport source(output valid, func, tag, level, input ready);
	modport sink(input valid, func, tag, level, output ready);
endinterface

interface tlpq_rsp_if import tlpq_pkg::*; ;
	logic                valid;
	logic                ready;
	logic [TAG_BITS-1:0] out_tag;
	logic [LVL_W-1:0]    out_level;
	logic [STS_W-1:0]    status;
	logic [CNT_W-1:0]    occupancy;

	modport source(output valid, out_tag, out_level, status, occupancy, input ready);
	modport sink(input valid, out_tag, out_level, status, occupancy, output ready);
endinterface

[src/tlpq_ctrl.sv]
// Operation sequencer: accept, memory access, commit.
module tlpq_ctrl import tlpq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  tlpq_sts_t sts,
	output tlpq_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_COMMIT
	} state_t;

	state_t state_q;

	assign in_ready   = (state_q == ST_IDLE);
	assign cmd.load   = in_valid && in_ready;
	assign cmd.exec   = (state_q == ST_EXEC);
	assign cmd.commit = (state_q == ST_COMMIT) && !sts.out_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					if (cmd.commit) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[src/tlpq_dp.sv]
// Datapath: tag and link memories, per-level list pointers, free list and result register.
module tlpq_dp import tlpq_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  tlpq_cmd_t           cmd,
	output tlpq_sts_t           sts,
	input  logic [FUNC_W-1:0]   in_func,
	input  logic [TAG_BITS-1:0] in_tag,
	input  logic [LVL_W-1:0]    in_level,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [TAG_BITS-1:0] out_tag,
	output logic [LVL_W-1:0]    out_level,
	output logic [STS_W-1:0]    out_status,
	output logic [CNT_W-1:0]    out_occupancy
);

	logic [ADDR_W-1:0]   link_mem [DEPTH];
	logic [TAG_BITS-1:0] tag_mem  [DEPTH];

	logic [FUNC_W-1:0]   func_q;
	logic [TAG_BITS-1:0] tag_q;
	logic [LVL_W-1:0]    lvl_q;

	logic [ADDR_W-1:0] heads_q [3];
	logic [ADDR_W-1:0] tails_q [3];
	logic [CNT_W-1:0]  counts_q [3];
	logic [ADDR_W-1:0] free_head_q;
	logic [CNT_W-1:0]  fresh_q;

	logic [ADDR_W-1:0] heads_d [3];
	logic [ADDR_W-1:0] tails_d [3];
	logic [CNT_W-1:0]  counts_d [3];
	logic [ADDR_W-1:0] free_head_d;
	logic [CNT_W-1:0]  fresh_d;

	logic [ADDR_W-1:0]   link_rd_q;
	logic [TAG_BITS-1:0] tag_rd_q;

	logic                out_valid_q;
	logic [TAG_BITS-1:0] out_tag_q;
	logic [LVL_W-1:0]    out_level_q;
	logic [STS_W-1:0]    out_status_q;
	logic [CNT_W-1:0]    out_occ_q;

	logic                link_we;
	logic [ADDR_W-1:0]   link_wa;
	logic [ADDR_W-1:0]   link_wd;
	logic                tag_we;
	logic                rd_en;
	logic [ADDR_W-1:0]   rd_addr;

	logic [CNT_W-1:0]    total;
	logic [CNT_W-1:0]    total_d;
	logic                full;
	logic                empty;
	logic [LVL_W-1:0]    found;
	logic                fresh_hit;
	logic [ADDR_W-1:0]   fresh_next;
	logic [TAG_BITS-1:0] res_tag;
	logic [LVL_W-1:0]    res_level;
	logic [STS_W-1:0]    res_status;

	assign total = counts_q[0] + counts_q[1] + counts_q[2];
	assign full  = (total == CNT_W'(DEPTH));
	assign empty = (total == '0);

	always_comb begin
		if (counts_q[2] != '0)      found = LVL_HIGH;
		else if (counts_q[1] != '0) found = LVL_NORMAL;
		else                        found = LVL_LOW;
	end

	// Slots at or above the fill count were never handed out and still chain to the next slot.
	assign fresh_hit  = (fresh_q < CNT_W'(DEPTH)) && (free_head_q == fresh_q[ADDR_W-1:0]);
	assign fresh_next = (fresh_q == CNT_W'(DEPTH - 1)) ? '0 : ADDR_W'(fresh_q + 1'b1);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			heads_d[i]  = heads_q[i];
			tails_d[i]  = tails_q[i];
			counts_d[i] = counts_q[i];
		end
		free_head_d = free_head_q;
		fresh_d     = fresh_q;
		link_we     = 1'b0;
		link_wa     = free_head_q;
		link_wd     = '0;
		tag_we      = 1'b0;
		rd_en       = 1'b0;
		rd_addr     = free_head_q;
		res_tag     = '0;
		res_level   = LVL_LOW;
		res_status  = STS_OK;

		if (cmd.exec) begin
			case (func_q)
				FUNC_PUT: begin
					if (!full) begin
						link_we = 1'b1;
						tag_we  = 1'b1;
						rd_en   = 1'b1;
					end
				end
				FUNC_GET: begin
					if (!empty) begin
						rd_en   = 1'b1;
						rd_addr = heads_q[found];
					end
				end
				FUNC_ACCEL: begin
					if (counts_q[LVL_LOW] != '0 && counts_q[LVL_HIGH] != '0) begin
						link_we = 1'b1;
						link_wa = tails_q[LVL_HIGH];
						link_wd = heads_q[LVL_LOW];
					end
				end
				default: ;
			endcase
		end

		if (cmd.commit) begin
			case (func_q)
				FUNC_PUT: begin
					if (full) begin
						res_status = STS_FULL;
					end else begin
						if (counts_q[lvl_q] != '0) begin
							link_we = 1'b1;
							link_wa = tails_q[lvl_q];
							link_wd = free_head_q;
						end else begin
							heads_d[lvl_q] = free_head_q;
						end
						tails_d[lvl_q]  = free_head_q;
						counts_d[lvl_q] = counts_q[lvl_q] + 1'b1;
						if (fresh_hit) begin
							free_head_d = fresh_next;
							fresh_d     = fresh_q + 1'b1;
						end else begin
							free_head_d = link_rd_q;
						end
					end
				end
				FUNC_GET: begin
					if (empty) begin
						res_status = STS_EMPTY;
					end else begin
						res_tag         = tag_rd_q;
						res_level       = found;
						heads_d[found]  = link_rd_q;
						counts_d[found] = counts_q[found] - 1'b1;
						link_we         = 1'b1;
						link_wa         = heads_q[found];
						link_wd         = free_head_q;
						free_head_d     = heads_q[found];
					end
				end
				FUNC_ACCEL: begin
					if (counts_q[LVL_LOW] != '0) begin
						if (counts_q[LVL_HIGH] == '0) heads_d[LVL_HIGH] = heads_q[LVL_LOW];
						tails_d[LVL_HIGH]  = tails_q[LVL_LOW];
						counts_d[LVL_HIGH] = counts_q[LVL_HIGH] + counts_q[LVL_LOW];
						counts_d[LVL_LOW]  = '0;
						heads_d[LVL_LOW]   = '0;
						tails_d[LVL_LOW]   = '0;
					end
				end
				default: ;
			endcase
		end
	end

	assign total_d = counts_d[0] + counts_d[1] + counts_d[2];

	always_ff @(posedge clk) begin
		if (link_we) link_mem[link_wa] <= link_wd;
		if (tag_we) tag_mem[free_head_q] <= tag_q;
		if (rd_en) begin
			link_rd_q <= link_mem[rd_addr];
			tag_rd_q  <= tag_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= in_func;
			tag_q  <= in_tag;
			lvl_q  <= (in_level == 2'd3) ? LVL_HIGH : in_level;
		end
		if (cmd.commit) begin
			out_tag_q    <= res_tag;
			out_level_q  <= res_level;
			out_status_q <= res_status;
			out_occ_q    <= total_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				heads_q[i]  <= '0;
				tails_q[i]  <= '0;
				counts_q[i] <= '0;
			end
			free_head_q <= '0;
			fresh_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				for (int i = 0; i < 3; i++) begin
					heads_q[i]  <= heads_d[i];
					tails_q[i]  <= tails_d[i];
					counts_q[i] <= counts_d[i];
				end
				free_head_q <= free_head_d;
				fresh_q     <= fresh_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.out_busy  = out_valid_q && !out_ready;
	assign out_valid     = out_valid_q;
	assign out_tag       = out_tag_q;
	assign out_level     = out_level_q;
	assign out_status    = out_status_q;
	assign out_occupancy = out_occ_q;

endmodule

[src/three_level_priority_queue.sv]
// Each operation (put, get, accelerate) goes from the accepted request beat to a loaded
// result in these steps: accept, access the synchronous tag and link memories, commit the
// list pointers and load the result register. The next request is accepted while an
// earlier result waits to be taken; the commit stalls only if that result is still held.
// The link memory needs no clearing pass after reset: a fill count marks the slots that
// were never handed out, so the block is usable straight after reset.
module three_level_priority_queue import tlpq_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	tlpq_req_if.sink  req,
	tlpq_rsp_if.source rsp
);

	tlpq_cmd_t cmd;
	tlpq_sts_t sts;

	tlpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tlpq_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.in_func       (req.func),
		.in_tag        (req.tag),
		.in_level      (req.level),
		.out_valid     (rsp.valid),
		.out_ready     (rsp.ready),
		.out_tag       (rsp.out_tag),
		.out_level     (rsp.out_level),
		.out_status    (rsp.status),
		.out_occupancy (rsp.occupancy)
	);

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.occupancy <= CNT_W'(DEPTH))
		else $error("occupancy above depth");

	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == STS_FULL |-> rsp.occupancy == CNT_W'(DEPTH))
		else $error("full status with free slots");

	a_empty_res: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == STS_EMPTY |-> rsp.occupancy == '0 && rsp.out_tag == '0)
		else $error("empty status with entries held");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("second beat accepted while busy");

endmodule
